[rtl/core/button_mode_and_light_control_macros.svh]
// ----------------------------------------------------------------------------
// Button mode and light control: assertion macros
// Shared assertion forms, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef BUTTON_MODE_AND_LIGHT_CONTROL_MACROS_SVH
`define BUTTON_MODE_AND_LIGHT_CONTROL_MACROS_SVH

// Check a condition or an overlapping implication at every clock edge.
`define BMLC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition in one cycle brings a consequence in the next one.
`define BMLC_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

[rtl/core/bmlc_pkg.sv]
// ----------------------------------------------------------------------------
// Button mode and light control package
// Codes, limits, reset values and the result record of the control block.
// ----------------------------------------------------------------------------
package bmlc_pkg;

  // Item kinds
  typedef enum logic [0:0] {
    OP_BUTTON = 1'b0,
    OP_LIGHT  = 1'b1
  } op_t;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_MAX_MODE       = 1'b0,
    REG_DARK_THRESHOLD = 1'b1
  } reg_index_t;

  localparam int CFG_DATA_W = 10;

  // Modes with a ramped value
  localparam logic [3:0] MODE_EFFECT       = 4'd1;
  localparam logic [3:0] MODE_RAINBOW      = 4'd2;
  localparam logic [3:0] MODE_RAINBOW_FAST = 4'd3;

  // Press timing in milliseconds
  localparam logic [31:0] LONG_PRESS_MS  = 32'd500;
  localparam logic [31:0] SHORT_PRESS_MS = 32'd50;

  // Value limits
  localparam logic [7:0] BRIGHT_MIN = 8'd10;
  localparam logic [7:0] BRIGHT_MAX = 8'd255;
  localparam logic [5:0] SPEED_MIN  = 6'd1;
  localparam logic [5:0] SPEED_MAX  = 6'd50;

  // Reset values
  localparam logic [3:0] MAX_MODE_RST       = 4'd3;
  localparam logic [9:0] DARK_THRESHOLD_RST = 10'd512;
  localparam logic [7:0] EFFECT_RST         = 8'd255;
  localparam logic [5:0] SPEED_RST          = 6'd10;
  localparam logic [7:0] AMBIENT_RST        = 8'd10;

  // One result item
  typedef struct packed {
    logic [3:0] mode;
    logic [7:0] effect_brightness;
    logic [5:0] rainbow_speed;
    logic [7:0] ambient_brightness;
    logic       dark;
    logic       short_press;
  } result_t;

endpackage

[rtl/core/button_mode_and_light_control.sv]
// ----------------------------------------------------------------------------
// Button mode and light control
// Front end of an LED strip controller. Each input item is a button scan
// (op 0) or a light sensor scan (op 1) stamped with a wrapping ms time.
// Input channel: in_valid / in_stall with op, button_level, now_ms and
// light_level. Output channel: out_valid / out_stall with one result item
// per input item: mode, effect_brightness, rainbow_speed,
// ambient_brightness, dark and short_press.
// The result is registered in the output register, or in the skid register.
// Throughput: one item per cycle while not stalled; the whole update is a
// short compare and step on a few registers before the result register.
// When the receiver stalls, the result holds in the output register and a
// skid register takes one more item; in_stall rises only once both are full.
// Reset (rst, synchronous) clears the press state, mode 0, effect 255,
// speed 10, ambient 10, max_mode 3, dark_threshold 512 and empties both
// output stages. Write configuration through cfg_we only while idle.
// ----------------------------------------------------------------------------
`include "button_mode_and_light_control_macros.svh"

module button_mode_and_light_control (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [0:0]                     cfg_index,
  input  logic [bmlc_pkg::CFG_DATA_W-1:0] cfg_data,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           op,
  input  logic                           button_level,
  input  logic [31:0]                    now_ms,
  input  logic [9:0]                     light_level,
  // output channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [3:0]                     mode,
  output logic [7:0]                     effect_brightness,
  output logic [5:0]                     rainbow_speed,
  output logic [7:0]                     ambient_brightness,
  output logic                           dark,
  output logic                           short_press
);

  // Configuration registers
  logic [3:0] max_mode;
  logic [9:0] dark_threshold;

  // Control state
  logic        press_active, press_active_next;
  logic [31:0] press_start, press_start_next;
  logic        ramp_up, ramp_up_next;
  logic [3:0]  mode_reg, mode_reg_next;
  logic [7:0]  effect_level, effect_level_next;
  logic [5:0]  speed_level, speed_level_next;
  logic [7:0]  ambient_level, ambient_level_next;
  logic        dark_flag, dark_flag_next;
  logic        short_done;

  // Output register and skid stage
  bmlc_pkg::result_t res_next, out_res, skid_res;
  logic              skid_valid;

  logic in_fire, out_fire;
  logic [31:0] elapsed;
  logic [31:0] start_eff;
  logic [4:0]  mode_inc;
  logic [7:0]  light_quarter;

  assign in_stall = skid_valid;
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;

  // --------------------------------------------------------------------------
  // Configuration writes
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      max_mode       <= bmlc_pkg::MAX_MODE_RST;
      dark_threshold <= bmlc_pkg::DARK_THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bmlc_pkg::REG_MAX_MODE:       max_mode       <= cfg_data[3:0];
        bmlc_pkg::REG_DARK_THRESHOLD: dark_threshold <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Per-item update
  // --------------------------------------------------------------------------
  // A fresh press starts at now_ms, so its elapsed time is zero.
  assign start_eff     = press_active ? press_start : now_ms;
  assign elapsed       = now_ms - start_eff;
  assign mode_inc      = {1'b0, mode_reg} + 5'd1;
  assign light_quarter = light_level[9:2];

  always_comb begin
    press_active_next  = press_active;
    press_start_next   = press_start;
    ramp_up_next       = ramp_up;
    mode_reg_next      = mode_reg;
    effect_level_next  = effect_level;
    speed_level_next   = speed_level;
    ambient_level_next = ambient_level;
    dark_flag_next     = dark_flag;
    short_done         = 1'b0;

    if (op == bmlc_pkg::OP_BUTTON) begin
      if (button_level) begin
        press_active_next = 1'b1;
        press_start_next  = start_eff;
        // Long hold: step the value of the current mode, clamped to its range.
        if (elapsed >= bmlc_pkg::LONG_PRESS_MS) begin
          case (mode_reg) inside
            bmlc_pkg::MODE_EFFECT: begin
              if (ramp_up) begin
                if (effect_level == bmlc_pkg::BRIGHT_MAX) begin
                  effect_level_next = bmlc_pkg::BRIGHT_MAX;
                end else if (effect_level + 8'd1 < bmlc_pkg::BRIGHT_MIN) begin
                  effect_level_next = bmlc_pkg::BRIGHT_MIN;
                end else begin
                  effect_level_next = effect_level + 8'd1;
                end
              end else begin
                if (effect_level <= bmlc_pkg::BRIGHT_MIN) begin
                  effect_level_next = bmlc_pkg::BRIGHT_MIN;
                end else begin
                  effect_level_next = effect_level - 8'd1;
                end
              end
            end
            bmlc_pkg::MODE_RAINBOW, bmlc_pkg::MODE_RAINBOW_FAST: begin
              if (ramp_up) begin
                if (speed_level >= bmlc_pkg::SPEED_MAX) begin
                  speed_level_next = bmlc_pkg::SPEED_MAX;
                end else begin
                  speed_level_next = speed_level + 6'd1;
                end
              end else begin
                if (speed_level <= bmlc_pkg::SPEED_MIN) begin
                  speed_level_next = bmlc_pkg::SPEED_MIN;
                end else if (speed_level > bmlc_pkg::SPEED_MAX + 6'd1) begin
                  speed_level_next = bmlc_pkg::SPEED_MAX;
                end else begin
                  speed_level_next = speed_level - 6'd1;
                end
              end
            end
            default: ;
          endcase
        end
      end else if (press_active) begin
        // Release: a short press advances the mode, wrapping past max_mode.
        if (elapsed < bmlc_pkg::LONG_PRESS_MS && elapsed > bmlc_pkg::SHORT_PRESS_MS) begin
          short_done = 1'b1;
          if (mode_inc > {1'b0, max_mode}) begin
            mode_reg_next = 4'd0;
          end else begin
            mode_reg_next = mode_inc[3:0];
          end
        end
        ramp_up_next      = !ramp_up;
        press_active_next = 1'b0;
      end
    end else begin
      if (light_level <= dark_threshold) begin
        if (light_quarter <= bmlc_pkg::BRIGHT_MIN) begin
          ambient_level_next = bmlc_pkg::BRIGHT_MIN;
        end else begin
          ambient_level_next = light_quarter;
        end
        dark_flag_next = 1'b1;
      end else begin
        // Bright scene: drop back to mode 0.
        mode_reg_next  = 4'd0;
        dark_flag_next = 1'b0;
      end
    end

    res_next.mode               = mode_reg_next;
    res_next.effect_brightness  = effect_level_next;
    res_next.rainbow_speed      = speed_level_next;
    res_next.ambient_brightness = ambient_level_next;
    res_next.dark               = dark_flag_next;
    res_next.short_press        = short_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_active  <= 1'b0;
      press_start   <= 32'd0;
      ramp_up       <= 1'b0;
      mode_reg      <= 4'd0;
      effect_level  <= bmlc_pkg::EFFECT_RST;
      speed_level   <= bmlc_pkg::SPEED_RST;
      ambient_level <= bmlc_pkg::AMBIENT_RST;
      dark_flag     <= 1'b0;
    end else if (in_fire) begin
      press_active  <= press_active_next;
      press_start   <= press_start_next;
      ramp_up       <= ramp_up_next;
      mode_reg      <= mode_reg_next;
      effect_level  <= effect_level_next;
      speed_level   <= speed_level_next;
      ambient_level <= ambient_level_next;
      dark_flag     <= dark_flag_next;
    end
  end

  // --------------------------------------------------------------------------
  // Output register with skid stage
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_fire) begin
      // Output stage free: drain the skid first, else load the new item.
      out_valid  <= skid_valid || in_fire;
      skid_valid <= 1'b0;
    end else if (in_fire) begin
      // Output held by the receiver: park the new item.
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_fire) begin
      out_res <= skid_valid ? skid_res : res_next;
    end
    if (out_valid && !out_fire && in_fire) begin
      skid_res <= res_next;
    end
  end

  assign mode               = out_res.mode;
  assign effect_brightness  = out_res.effect_brightness;
  assign rainbow_speed      = out_res.rainbow_speed;
  assign ambient_brightness = out_res.ambient_brightness;
  assign dark               = out_res.dark;
  assign short_press        = out_res.short_press;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `BMLC_ASSERT(a_skid_behind_out, skid_valid |-> out_valid, "skid item without output item")
  `BMLC_ASSERT_NEXT(a_park_on_stall, out_valid && out_stall && in_fire, skid_valid,
    "item accepted under stall was not parked")
  `BMLC_ASSERT_NEXT(a_light_result, in_fire && op == bmlc_pkg::OP_LIGHT,
    mode_reg == 4'd0 || dark_flag, "bright light scan left a nonzero mode")
  `BMLC_ASSERT(a_levels_in_range,
    effect_level >= bmlc_pkg::BRIGHT_MIN && speed_level >= bmlc_pkg::SPEED_MIN &&
    speed_level <= bmlc_pkg::SPEED_MAX && ambient_level >= bmlc_pkg::BRIGHT_MIN,
    "stored level out of range")

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button mode and light control testbench
// Drives button and light scans through the valid/stall channel with random
// sender gaps and receiver stalls. A scoreboard class tracks press timing,
// mode, ramped levels and ambient state, and checks every result in order.
// ----------------------------------------------------------------------------
module tb;

  // Mirrors the strip controller state and holds the results still owed.
  class strip_control_scoreboard;
    logic [3:0]  max_mode;
    logic [9:0]  dark_threshold;
    bit          press_active;
    logic [31:0] press_start;
    bit          ramp_up;
    logic [3:0]  mode_q;
    logic [7:0]  effect_q;
    logic [5:0]  speed_q;
    logic [7:0]  ambient_q;
    bit          dark_q;
    bmlc_pkg::result_t owed_results[$];
    int          errors;

    function new();
      max_mode       = bmlc_pkg::MAX_MODE_RST;
      dark_threshold = bmlc_pkg::DARK_THRESHOLD_RST;
      press_active   = 1'b0;
      press_start    = '0;
      ramp_up        = 1'b0;
      mode_q         = '0;
      effect_q       = bmlc_pkg::EFFECT_RST;
      speed_q        = bmlc_pkg::SPEED_RST;
      ambient_q      = bmlc_pkg::AMBIENT_RST;
      dark_q         = 1'b0;
      errors         = 0;
    endfunction

    function void write_reg(bmlc_pkg::reg_index_t idx, logic [9:0] data);
      case (idx)
        bmlc_pkg::REG_MAX_MODE:       max_mode = data[3:0];
        bmlc_pkg::REG_DARK_THRESHOLD: dark_threshold = data;
        default: ;
      endcase
    endfunction

    function int step_level(int v, bit up, int lo, int hi);
      int x;
      x = up ? v + 1 : v - 1;
      if (x < lo) x = lo;
      if (x > hi) x = hi;
      return x;
    endfunction

    // Update the mirrored state for one accepted scan and owe its result.
    function void apply_scan(bmlc_pkg::op_t kind, bit pressed, logic [31:0] t,
                             logic [9:0] lvl);
      logic [31:0] held;
      logic [7:0]  quarter;
      bmlc_pkg::result_t r;
      bit          short_done;
      short_done = 1'b0;
      if (kind == bmlc_pkg::OP_BUTTON) begin
        if (pressed) begin
          if (!press_active) begin
            press_start  = t;
            press_active = 1'b1;
          end
          held = t - press_start;
          if (held >= bmlc_pkg::LONG_PRESS_MS) begin
            if (mode_q == bmlc_pkg::MODE_EFFECT)
              effect_q = 8'(step_level(int'(effect_q), ramp_up,
                                       int'(bmlc_pkg::BRIGHT_MIN),
                                       int'(bmlc_pkg::BRIGHT_MAX)));
            else if (mode_q == bmlc_pkg::MODE_RAINBOW ||
                     mode_q == bmlc_pkg::MODE_RAINBOW_FAST)
              speed_q = 6'(step_level(int'(speed_q), ramp_up,
                                      int'(bmlc_pkg::SPEED_MIN),
                                      int'(bmlc_pkg::SPEED_MAX)));
          end
        end else if (press_active) begin
          held = t - press_start;
          if (held > bmlc_pkg::SHORT_PRESS_MS && held < bmlc_pkg::LONG_PRESS_MS) begin
            short_done = 1'b1;
            mode_q = (mode_q >= max_mode) ? 4'd0 : mode_q + 4'd1;
          end
          ramp_up      = !ramp_up;
          press_active = 1'b0;
        end
      end else begin
        if (lvl <= dark_threshold) begin
          quarter   = 8'(lvl >> 2);
          ambient_q = (quarter <= bmlc_pkg::BRIGHT_MIN) ? bmlc_pkg::BRIGHT_MIN : quarter;
          dark_q    = 1'b1;
        end else begin
          mode_q = '0;
          dark_q = 1'b0;
        end
      end
      r.mode               = mode_q;
      r.effect_brightness  = effect_q;
      r.rainbow_speed      = speed_q;
      r.ambient_brightness = ambient_q;
      r.dark               = dark_q;
      r.short_press        = short_done;
      owed_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_scan_result(bmlc_pkg::result_t got);
      bmlc_pkg::result_t want;
      if (owed_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = owed_results.pop_front();
      compare_field("mode", 8'(want.mode), 8'(got.mode));
      compare_field("effect_brightness", want.effect_brightness, got.effect_brightness);
      compare_field("rainbow_speed", 8'(want.rainbow_speed), 8'(got.rainbow_speed));
      compare_field("ambient_brightness", want.ambient_brightness, got.ambient_brightness);
      compare_field("dark", 8'(want.dark), 8'(got.dark));
      compare_field("short_press", 8'(want.short_press), 8'(got.short_press));
    endfunction
  endclass

  localparam int unsigned CYCLE_LIMIT = 200000;

  // Every input of the block starts at a known value.
  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_we = 1'b0;
  logic [0:0]                      cfg_index = '0;
  logic [bmlc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic                            op = 1'b0;
  logic                            button_level = 1'b0;
  logic [31:0]                     now_ms = '0;
  logic [9:0]                      light_level = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [3:0]                      mode;
  logic [7:0]                      effect_brightness;
  logic [5:0]                      rainbow_speed;
  logic [7:0]                      ambient_brightness;
  logic                            dark;
  logic                            short_press;

  strip_control_scoreboard sb;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  logic [31:0] clock_ms;

  button_mode_and_light_control u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver side: stall at random with the current percentage.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watch both channels. Values read here are the ones that were present
  // at this edge, since everything else moves by nonblocking updates.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        sb.apply_scan(bmlc_pkg::op_t'(op), button_level, now_ms, light_level);
      if (out_valid && !out_stall)
        sb.check_scan_result({mode, effect_brightness, rainbow_speed,
                              ambient_brightness, dark, short_press});
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offer one item, idling first at random, and hold it until accepted.
  // Called at a rising edge; returns at the edge that took the item.
  task automatic send_item(bmlc_pkg::op_t kind, bit pressed, logic [31:0] t,
                           logic [9:0] lvl);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    op           <= kind;
    button_level <= pressed;
    now_ms       <= t;
    light_level  <= lvl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Button scans carry a random, ignored light level.
  task automatic send_button(bit pressed, logic [31:0] t);
    send_item(bmlc_pkg::OP_BUTTON, pressed, t, 10'($urandom_range(1023)));
  endtask

  // Light scans carry a random, ignored button level.
  task automatic send_light(logic [9:0] lvl, logic [31:0] t);
    send_item(bmlc_pkg::OP_LIGHT, 1'($urandom_range(1)), t, lvl);
  endtask

  // Drop valid and hold until every owed result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.owed_results.size() != 0) @(posedge clk);
  endtask

  // Write one register; only called while the block is idle.
  task automatic write_reg(bmlc_pkg::reg_index_t idx, logic [9:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  // Pick a release time relative to the press, hugging the short and long
  // press boundaries and sometimes wrapping far around.
  function automatic logic [31:0] pick_release();
    case ($urandom_range(9))
      0:       return $urandom_range(0, 50);
      1:       return 32'd50;
      2:       return 32'd51;
      3:       return 32'd499;
      4:       return 32'd500;
      5, 6:    return $urandom_range(51, 499);
      7:       return $urandom_range(500, 5000);
      8:       return $urandom();
      default: return $urandom_range(0, 1000);
    endcase
  endfunction

  // One press: the press edge, n_hold held scans starting at hold_from ms
  // after the press, then the release at release_at ms after the press.
  // Light scans may slip in between held scans when mix_light is set.
  task automatic press_cycle(int unsigned n_hold, logic [31:0] hold_from,
                             logic [31:0] release_at, bit mix_light);
    logic [31:0] t0;
    logic [31:0] e;
    t0 = clock_ms;
    e  = hold_from;
    send_button(1'b1, t0);
    repeat (n_hold) begin
      if (mix_light && $urandom_range(9) == 0)
        send_light(10'($urandom_range(1023)), t0 + e);
      send_button(1'b1, t0 + e);
      e = e + $urandom_range(0, 25);
    end
    send_button(1'b0, t0 + release_at);
    clock_ms = t0 + release_at + $urandom_range(1, 3000);
  endtask

  // Walk the mode forward with short presses, then fix the ramp direction
  // with quick taps, watching the mirrored state after each press.
  task automatic steer_to(logic [3:0] target, bit up);
    int unsigned tries;
    tries = 0;
    wait_drained();
    while (!(sb.mode_q == target && sb.ramp_up == up) && tries < 40) begin
      if (sb.mode_q != target)
        press_cycle($urandom_range(0, 2), 0, $urandom_range(51, 499), 1'b0);
      else
        press_cycle(0, 0, $urandom_range(0, 50), 1'b0);
      wait_drained();
      tries++;
    end
  endtask

  // Hold the button long enough for n ramp steps in the target mode.
  task automatic ramp_run(logic [3:0] target, bit up, int unsigned n);
    steer_to(target, up);
    press_cycle(n, bmlc_pkg::LONG_PRESS_MS, $urandom_range(500, 100000), 1'b0);
  endtask

  // Random mix of presses, light scans and stray button scans. Halfway
  // through, pause until the block has returned every owed result.
  task automatic random_traffic(int unsigned count);
    int unsigned goal;
    int unsigned half;
    int unsigned pick;
    bit          paused;
    logic [9:0]  lvl;
    goal   = items_sent + count;
    half   = items_sent + count / 2;
    paused = 1'b0;
    while (items_sent < goal) begin
      if (!paused && items_sent >= half) begin
        wait_drained();
        paused = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 15) begin
        case ($urandom_range(7))
          0:       lvl = 10'd0;
          1:       lvl = 10'h3FF;
          2:       lvl = sb.dark_threshold;
          3:       lvl = sb.dark_threshold + 10'd1;
          4:       lvl = 10'($urandom_range(36, 47));
          default: lvl = 10'($urandom_range(1023));
        endcase
        send_light(lvl, clock_ms);
        clock_ms = clock_ms + $urandom_range(1, 2000);
      end else if (pick < 25) begin
        // Stray scan at an arbitrary time.
        send_button(1'($urandom_range(1)), $urandom());
      end else if (pick < 62) begin
        press_cycle(($urandom_range(3) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 6),
                    $urandom_range(300, 700), pick_release(), 1'b1);
      end else begin
        press_cycle($urandom_range(0, 3), $urandom_range(0, 60), pick_release(), 1'b1);
      end
    end
  endtask

  initial begin
    sb = new();
    clock_ms = $urandom();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Phase one: reset configuration, sender idles less than receiver.
    send_idle_pct = 34;
    stall_pct     = 54;

    // Light scans: dark floor, bright ceiling, both sides of the threshold,
    // and the quarter level right at the ambient floor.
    send_light(10'd0, 32'h0000_0000);
    send_light(10'h3FF, 32'hFFFF_FFFF);
    send_light(10'd512, 32'h0000_0010);
    send_light(10'd513, 32'h0000_0020);
    send_light(10'd43, 32'h0000_0030);
    send_light(10'd44, 32'h0000_0040);
    // Release with no press held changes nothing.
    send_button(1'b0, 32'h5555_5555);
    // Short press across the time wrap, 51 ms: advance to the effect mode.
    send_button(1'b1, 32'hFFFF_FFE0);
    send_button(1'b0, 32'h0000_0013);
    // Exactly 50 ms is too quick to count; the ramp direction still flips.
    send_button(1'b1, 32'd100);
    send_button(1'b0, 32'd150);
    // Long hold in the effect mode: no step at 499, steps at 500 and on a
    // scan stamped before the press (elapsed wraps huge); release at 500.
    send_button(1'b1, 32'd1000);
    send_button(1'b1, 32'd1499);
    send_button(1'b1, 32'd1500);
    send_button(1'b1, 32'd999);
    send_button(1'b0, 32'd1500);
    // Ramp up one step toward the ceiling, then a 499 ms release advances.
    send_button(1'b1, 32'd2000);
    send_button(1'b1, 32'd2600);
    send_button(1'b0, 32'd2499);
    // Speed step in the rainbow mode, release at zero elapsed.
    send_button(1'b1, 32'd3000);
    send_button(1'b1, 32'd3500);
    send_button(1'b0, 32'd3000);
    // Bright scene forces mode zero.
    send_light(10'h3FF, 32'd4000);

    random_traffic(30);
    wait_drained();

    // Phase two: top mode limit, every light is dark, roles swapped.
    write_reg(bmlc_pkg::REG_MAX_MODE, 10'd15);
    write_reg(bmlc_pkg::REG_DARK_THRESHOLD, 10'd1023);
    send_idle_pct = 54;
    stall_pct     = 34;
    ramp_run(bmlc_pkg::MODE_EFFECT, 1'b0, 250);
    ramp_run(bmlc_pkg::MODE_RAINBOW, 1'b1, 45);
    random_traffic(30);
    // Park the mode well above the limit that comes next.
    steer_to(4'd12, 1'($urandom_range(1)));

    // Phase three: lowest mode limit, only a zero light level is dark,
    // no idling on either side.
    write_reg(bmlc_pkg::REG_MAX_MODE, 10'(bmlc_pkg::MAX_MODE_RST));
    write_reg(bmlc_pkg::REG_DARK_THRESHOLD, 10'd0);
    send_idle_pct = 0;
    stall_pct     = 0;
    // A short press from above the new limit wraps to zero.
    press_cycle(0, 0, 32'd200, 1'b0);
    ramp_run(bmlc_pkg::MODE_RAINBOW_FAST, 1'b0, 55);
    random_traffic(20);
    wait_drained();

    // Last phase: random configuration.
    write_reg(bmlc_pkg::REG_MAX_MODE, 10'($urandom_range(3, 15)));
    write_reg(bmlc_pkg::REG_DARK_THRESHOLD, 10'($urandom_range(1023)));
    random_traffic(20);

    wait_drained();
    repeat (4) @(posedge clk);
    if (sb.errors == 0 && sb.owed_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
